// File: hdl/running_mean_sigma_outlier_defines.svh
// assertion macros for the running mean and sigma block
`ifndef RUNNING_MEAN_SIGMA_OUTLIER_DEFINES_SVH
`define RUNNING_MEAN_SIGMA_OUTLIER_DEFINES_SVH

`ifndef SYNTH
`define RMSO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmso check failed");
`define RMSO_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rmso reset check failed");
`else
`define RMSO_ASSERT(lbl, prop)
`define RMSO_ASSERT_NORST(lbl, prop)
`endif

`endif

// File: hdl/rmso_pkg.sv
// types, widths and sequencer states of the running mean and sigma block
package rmso_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_BITS  = 16;

  localparam int MEAN_W  = 32;
  localparam int SIG_W   = 32;
  localparam int THR_W   = 16;
  localparam int OCNT_W  = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd768;
  localparam int THR_FRAC = 8;

  localparam int SQ_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int DW    = ((SQ_W > MEAN_W) ? SQ_W : MEAN_W) + 1;
  localparam int SUM_A = 2 * SIG_W + COUNT_BITS;
  localparam int SUM_B = 2 * DW;
  localparam int AW0   = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;
  localparam int AW    = AW0 + (AW0 % 2);
  localparam int RTW   = AW / 2;
  localparam int SR    = ((COUNT_BITS + 2) > (RTW + 2)) ? (COUNT_BITS + 2) : (RTW + 2);
  localparam int OBW0  = (SIG_W > DW) ? SIG_W : DW;
  localparam int OBW1  = (OBW0 > COUNT_BITS) ? OBW0 : COUNT_BITS;
  localparam int OBW   = (OBW1 > THR_W) ? OBW1 : THR_W;
  localparam int CW    = $clog2(AW + 1);
  localparam int DVW   = COUNT_BITS + 1;
  localparam int ZW    = (COUNT_BITS > OCNT_W) ? COUNT_BITS : OCNT_W;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SAVE   = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } rmso_in_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_value;
    logic [SIG_W-1:0]         sigma_value;
    logic                     within_threshold;
    logic [OCNT_W-1:0]        averaged_count;
  } rmso_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OUT_MUL, ST_OUT_CMP, ST_MEAN_MUL, ST_MEAN_SUM, ST_MEAN_RND,
    ST_MEAN_DIV, ST_MEAN_SAT, ST_COUNT, ST_SIG_MUL1, ST_SIG_MUL2, ST_SIG_MUL3,
    ST_SIG_DIV, ST_SQRT, ST_SIG_SAT, ST_DONE
  } rmso_state_t;

endpackage

// File: hdl/running_mean_sigma_outlier.sv
// running mean and deviation with outlier reset, one shared serial unit
//
//  channel | ports                          | direction
//  in      | in_valid, in_stall, in_data    | request in, stall out
//  out     | out_valid, out_stall, out_data | request out, stall in
//  cfg     | cfg_we, cfg_wdata              | threshold write
//
// a sample request runs the bit-serial multiply (one multiplier bit a cycle),
// up to two restoring divides over the 82-bit accumulator and a 41-step square
// root; a save request goes straight to the output.
// synchronous active-low reset clears state and loads the threshold to 3.0.
// a new request is taken while a result still waits under out_stall.
module running_mean_sigma_outlier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmso_pkg::rmso_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmso_pkg::rmso_out_t out_data,
  input  logic                cfg_we,
  input  logic [rmso_pkg::THR_W-1:0] cfg_wdata
);
  import rmso_pkg::*;
  `include "running_mean_sigma_outlier_defines.svh"

  function automatic logic [MEAN_W-1:0] sat_mean(input logic neg, input logic [AW-1:0] mag);
    logic big;
    big = (mag >> (MEAN_W - 1)) != '0;
    if (neg) begin
      sat_mean = big ? {1'b1, {(MEAN_W-1){1'b0}}} : (~mag[MEAN_W-1:0] + 1'b1);
    end else begin
      sat_mean = big ? {1'b0, {(MEAN_W-1){1'b1}}} : mag[MEAN_W-1:0];
    end
  endfunction

  rmso_state_t state_r, state_nxt;

  logic signed [MEAN_W-1:0] mean_r, mean_nxt;
  logic [SIG_W-1:0]         sigma_r, sigma_nxt;
  logic [COUNT_BITS-1:0]    count_r, count_nxt;
  logic                     flag_r, flag_nxt;
  logic [THR_W-1:0]         thr_r, thr_nxt;
  logic signed [SQ_W-1:0]   sq_r, sq_nxt;
  logic [DW-1:0]            dmag_r, dmag_nxt;
  logic                     neg_r, neg_nxt;
  logic [AW-1:0]            acc_r, acc_nxt;
  logic [AW-1:0]            opa_r, opa_nxt;
  logic [OBW-1:0]           opb_r, opb_nxt;
  logic [SR-1:0]            rem_r, rem_nxt;
  logic [RTW-1:0]           root_r, root_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [DVW-1:0]           div_r, div_nxt;
  rmso_out_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic signed [SQ_W-1:0] sq_in;
  logic signed [DW-1:0]   delta;
  logic [MEAN_W-1:0]      mean_abs;
  logic [AW-1:0]          mul_sum;
  logic [SR+1:0]          sub_x, sub_y;
  logic [SR+2:0]          sub_full;
  logic                   sub_ge;
  logic                   sqrt_mode;
  logic signed [AW:0]     prod_s, num_s;
  logic [AW-1:0]          sq_mag;
  logic                   outlier;
  logic [COUNT_BITS-1:0]  cnew;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared compare-subtract for division and square root
  assign sqrt_mode = (state_r == ST_SQRT);
  assign sub_x     = sqrt_mode ? {rem_r, acc_r[AW-1 -: 2]} : {1'b0, rem_r, acc_r[AW-1]};
  assign sub_y     = sqrt_mode ? (SR+2)'({root_r, 2'b01}) : (SR+2)'(div_r);
  assign sub_full  = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_ge    = !sub_full[SR+2];
  assign mul_sum   = acc_r + (opb_r[0] ? opa_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r      <= '0;
      sigma_r     <= '0;
      count_r     <= '0;
      flag_r      <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mean_r      <= mean_nxt;
      sigma_r     <= sigma_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sq_r   <= sq_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    div_r  <= div_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mean_nxt      = mean_r;
    sigma_nxt     = sigma_r;
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    thr_nxt       = cfg_we ? cfg_wdata : thr_r;
    sq_nxt        = sq_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    div_nxt       = div_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    sq_in    = SQ_W'(in_data.sample_value) <<< FRAC_BITS;
    delta    = DW'(sq_in) - DW'(mean_r);
    mean_abs = mean_r[MEAN_W-1] ? (~mean_r + 1'b1) : mean_r;
    prod_s   = mean_r[MEAN_W-1] ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    num_s    = prod_s + (AW+1)'(sq_r);
    sq_mag   = sq_r[SQ_W-1] ? AW'(-(AW+1)'(sq_r)) : AW'(sq_r);
    outlier  = (AW'(dmag_r) << THR_FRAC) > acc_r;
    cnew     = (count_r == {COUNT_BITS{1'b1}}) ? count_r : count_r + 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_SAVE) begin
            if (!flag_r) begin
              count_nxt = '0;
            end
            state_nxt = ST_DONE;
          end else begin
            sq_nxt   = sq_in;
            dmag_nxt = delta[DW-1] ? DW'(-delta) : DW'(delta);
            acc_nxt  = '0;
            if (sigma_r != '0) begin
              opa_nxt   = AW'(sigma_r);
              opb_nxt   = OBW'(thr_r);
              state_nxt = ST_OUT_MUL;
            end else begin
              opa_nxt   = AW'(mean_abs);
              opb_nxt   = OBW'(count_r);
              div_nxt   = DVW'(count_r) + 1'b1;
              state_nxt = ST_MEAN_MUL;
            end
          end
        end
      end
      ST_OUT_MUL: begin
        if (opb_r == '0) begin
          state_nxt = ST_OUT_CMP;
        end else begin
          acc_nxt = mul_sum;
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
        end
      end
      ST_OUT_CMP: begin
        if (outlier) begin
          flag_nxt  = 1'b1;
          mean_nxt  = sat_mean(sq_r[SQ_W-1], sq_mag);
          count_nxt = '0;
          state_nxt = ST_COUNT;
        end else begin
          acc_nxt   = '0;
          opa_nxt   = AW'(mean_abs);
          opb_nxt   = OBW'(count_r);
          div_nxt   = DVW'(count_r) + 1'b1;
          state_nxt = ST_MEAN_MUL;
        end
      end
      ST_MEAN_MUL: begin
        if (opb_r == '0) begin
          state_nxt = ST_MEAN_SUM;
        end else begin
          acc_nxt = mul_sum;
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
        end
      end
      ST_MEAN_SUM: begin
        neg_nxt   = num_s[AW];
        acc_nxt   = num_s[AW] ? AW'(-num_s) : AW'(num_s);
        state_nxt = ST_MEAN_RND;
      end
      ST_MEAN_RND: begin
        acc_nxt   = acc_r + AW'(div_r >> 1);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        rem_nxt = sub_ge ? sub_full[SR-1:0] : sub_x[SR-1:0];
        acc_nxt = {acc_r[AW-2:0], sub_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(AW - 1)) begin
          state_nxt = ST_MEAN_SAT;
        end
      end
      ST_MEAN_SAT: begin
        mean_nxt  = sat_mean(neg_r, acc_r);
        flag_nxt  = 1'b0;
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        count_nxt = cnew;
        acc_nxt   = '0;
        opa_nxt   = AW'(sigma_r);
        opb_nxt   = OBW'(cnew);
        div_nxt   = DVW'(cnew) + 1'b1;
        state_nxt = ST_SIG_MUL1;
      end
      ST_SIG_MUL1: begin
        if (opb_r == '0) begin
          opa_nxt   = acc_r;
          opb_nxt   = OBW'(sigma_r);
          acc_nxt   = '0;
          state_nxt = ST_SIG_MUL2;
        end else begin
          acc_nxt = mul_sum;
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
        end
      end
      ST_SIG_MUL2: begin
        if (opb_r == '0) begin
          opa_nxt   = AW'(dmag_r);
          opb_nxt   = OBW'(dmag_r);
          state_nxt = ST_SIG_MUL3;
        end else begin
          acc_nxt = mul_sum;
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
        end
      end
      ST_SIG_MUL3: begin
        if (opb_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SIG_DIV;
        end else begin
          acc_nxt = mul_sum;
          opa_nxt = opa_r << 1;
          opb_nxt = opb_r >> 1;
        end
      end
      ST_SIG_DIV: begin
        rem_nxt = sub_ge ? sub_full[SR-1:0] : sub_x[SR-1:0];
        acc_nxt = {acc_r[AW-2:0], sub_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(AW - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_nxt  = sub_ge ? sub_full[SR-1:0] : sub_x[SR-1:0];
        acc_nxt  = acc_r << 2;
        root_nxt = {root_r[RTW-2:0], sub_ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(RTW - 1)) begin
          state_nxt = ST_SIG_SAT;
        end
      end
      ST_SIG_SAT: begin
        sigma_nxt = ((root_r >> SIG_W) != '0) ? {SIG_W{1'b1}} : root_r[SIG_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.mean_value       = mean_r;
          out_nxt.sigma_value      = sigma_r;
          out_nxt.within_threshold = !flag_r;
          out_nxt.averaged_count   = (ZW'(count_r) > ZW'({OCNT_W{1'b1}})) ?
                                     {OCNT_W{1'b1}} : OCNT_W'(count_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `RMSO_ASSERT(a_sample_starts_work,
    (in_valid && !in_stall && in_data.kind == KIND_SAMPLE) |=>
    (state_r != ST_IDLE && state_r != ST_DONE))
  `RMSO_ASSERT(a_outlier_restarts_count,
    (state_r == ST_COUNT && flag_r) |=> (count_r == COUNT_BITS'(1)))
  `RMSO_ASSERT(a_divisor_nonzero,
    (state_r == ST_MEAN_DIV || state_r == ST_SIG_DIV) |-> (div_r != '0))
  `RMSO_ASSERT_NORST(a_reset_clears_result,
    !rst_n |=> !out_valid_r)

endmodule

// File: dv/testbench.sv
// self-checking testbench for the running mean and sigma block with outlier reset
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmso_pkg::*;

  class stats_tracker;
    longint mean_q8;
    logic [63:0] sigma_q8;
    longint count;
    bit outlier;
    logic [63:0] thr;
    rmso_out_t expected_stats[$];
    int mismatches;

    function new();
      mean_q8 = 0;
      sigma_q8 = 0;
      count = 0;
      outlier = 0;
      thr = 64'(THR_RESET);
      mismatches = 0;
    endfunction

    function longint clamp_mean(bit neg, logic [63:0] mag);
      if (neg) return (mag >= 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(mag);
      return (mag > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(mag);
    endfunction

    function void set_threshold(logic [THR_W-1:0] v);
      thr = 64'(v);
    endfunction

    function void note_request(rmso_in_t req);
      longint s, sq, delta, num;
      logic [63:0] dmag, mag, d;
      logic [127:0] acc, q, t, root;
      bit neg;
      rmso_out_t e;
      if (req.kind == KIND_SAMPLE) begin
        s = longint'(req.sample_value);
        sq = s * 256;
        delta = sq - mean_q8;
        dmag = (delta < 0) ? 64'(-delta) : 64'(delta);
        if (sigma_q8 != 0 && dmag * 256 > sigma_q8 * thr) begin
          outlier = 1;
          mean_q8 = clamp_mean(sq < 0, (sq < 0) ? 64'(-sq) : 64'(sq));
          count = 0;
        end else begin
          outlier = 0;
          d = 64'(count + 1);
          num = mean_q8 * count + sq;
          neg = num < 0;
          mag = neg ? 64'(-num) : 64'(num);
          mag = (mag + d / 2) / d;
          mean_q8 = clamp_mean(neg, mag);
        end
        if (count < 65535) count++;
        acc = 128'(sigma_q8) * 128'(sigma_q8) * 128'(count) + 128'(dmag) * 128'(dmag);
        q = acc / 128'(count + 1);
        root = 0;
        for (int b = 63; b >= 0; b--) begin
          t = root | (128'd1 << b);
          if (t * t <= q) root = t;
        end
        sigma_q8 = (root > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : root[63:0];
      end else if (!outlier) begin
        count = 0;
      end
      e.mean_value = mean_q8[31:0];
      e.sigma_value = sigma_q8[31:0];
      e.within_threshold = !outlier;
      e.averaged_count = (count > 65535) ? 16'hFFFF : count[15:0];
      expected_stats.push_back(e);
    endfunction

    function void check_result(rmso_out_t got);
      rmso_out_t e;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_stats.pop_front();
      if (got.mean_value !== e.mean_value || got.sigma_value !== e.sigma_value ||
          got.within_threshold !== e.within_threshold ||
          got.averaged_count !== e.averaged_count) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  rmso_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  rmso_out_t out_data;
  logic cfg_we = 0;
  logic [THR_W-1:0] cfg_wdata = '0;

  stats_tracker tracker = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  longint base_value = 0;

  running_mean_sigma_outlier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_request(in_data);
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(bit kind, logic signed [SAMPLE_BITS-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1;
    in_data.kind <= kind;
    in_data.sample_value <= value;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.expected_stats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    tracker.set_threshold(v);
    @(negedge clk);
  endtask

  task automatic send_random();
    int pick;
    longint v;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send(KIND_SAVE, SAMPLE_BITS'($urandom));
    end else if (pick < 70) begin
      v = base_value + $signed($urandom_range(64)) - 32;
      send(KIND_SAMPLE, v[SAMPLE_BITS-1:0]);
    end else if (pick < 85) begin
      base_value = longint'($signed(SAMPLE_BITS'($urandom)));
      send(KIND_SAMPLE, base_value[SAMPLE_BITS-1:0]);
    end else begin
      send(KIND_SAMPLE, SAMPLE_BITS'($urandom));
    end
  endtask

  initial begin
    logic [THR_W-1:0] thresholds[6];
    thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd0, 16'd768};
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // extremes, repeated values, outliers and saves at the reset threshold
    send(KIND_SAVE, 0);
    send(KIND_SAMPLE, 24'sd8388607);
    send(KIND_SAMPLE, 24'sd8388607);
    send(KIND_SAMPLE, -24'sd8388608);
    send(KIND_SAMPLE, -24'sd8388608);
    send(KIND_SAMPLE, 0);
    send(KIND_SAMPLE, -1);
    send(KIND_SAMPLE, 1);
    send(KIND_SAVE, 24'hFFFFFF);
    send(KIND_SAMPLE, 100);
    send(KIND_SAMPLE, 102);
    send(KIND_SAMPLE, 98);
    send(KIND_SAMPLE, 101);
    send(KIND_SAMPLE, 5000);
    send(KIND_SAVE, 0);
    send(KIND_SAMPLE, 5001);
    send(KIND_SAMPLE, 4999);
    send(KIND_SAVE, 0);
    send(KIND_SAMPLE, -3);
    send(KIND_SAMPLE, -3);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_threshold(thresholds[p] == 16'd0 && p == 4 ? 16'($urandom) : thresholds[p]);
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 57; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 57; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      if (p == 1) hold_request = 1;
      for (int i = 0; i < 88; i++) begin
        if (p == 0 && i == 40) begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        send_random();
      end
      drain();
    end

    repeat (400) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_stats.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/rmso_pkg.sv
hdl/running_mean_sigma_outlier.sv
dv/testbench.sv
